### rtl/rsi_pkg.sv
`timescale 1ns / 1ps

package rsi_pkg;

    // Result status of one intersection test.
    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_MISS  = 2'd1,
        ST_DEGEN = 2'd2
    } status_t;

endpackage

### rtl/rsi_mul.sv
`timescale 1ns / 1ps

// Signed multiplier split into four half-width partial products.
// Partial products are registered, then summed and registered.
module rsi_mul #(
    parameter int A_WIDTH = 32,
    parameter int B_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int AL = A_WIDTH / 2;
    localparam int AH = A_WIDTH - AL;
    localparam int BL = B_WIDTH / 2;
    localparam int BH = B_WIDTH - BL;
    localparam int PW = A_WIDTH + B_WIDTH;

    logic signed [AH-1:0]      a_hi;
    logic        [AL-1:0]      a_lo;
    logic signed [BH-1:0]      b_hi;
    logic        [BL-1:0]      b_lo;
    logic signed [AH+BH-1:0]   hh_reg;
    logic signed [AH+BL:0]     hl_reg;
    logic signed [AL+BH:0]     lh_reg;
    logic        [AL+BL-1:0]   ll_reg;
    logic signed [PW-1:0]      p_reg;

    assign a_hi = a[A_WIDTH-1:AL];
    assign a_lo = a[AL-1:0];
    assign b_hi = b[B_WIDTH-1:BL];
    assign b_lo = b[BL-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= (AH+BH)'(a_hi) * (AH+BH)'(b_hi);
            hl_reg <= (AH+BL+1)'(a_hi) * (AH+BL+1)'($signed({1'b0, b_lo}));
            lh_reg <= (AL+BH+1)'($signed({1'b0, a_lo})) * (AL+BH+1)'(b_hi);
            ll_reg <= (AL+BL)'(a_lo) * (AL+BL)'(b_lo);
            p_reg  <= (PW'(hh_reg) <<< (AL + BL)) + (PW'(hl_reg) <<< AL)
                    + (PW'(lh_reg) <<< BL) + $signed(PW'(ll_reg));
        end
    end

    assign p = p_reg;

endmodule

### rtl/ray_sphere_intersect.sv
`timescale 1ns / 1ps

// Channel | Handshake              | Payload
// --------+------------------------+---------------------------------------------
// in      | in_valid / in_ready    | center_x/y/z, sphere_radius, origin_x/y/z,
//         |                        | dir_x/y/z
// out     | out_valid / out_ready  | status, hit_distance, saturated
//
// One item per cycle sustained while the output is not stalled; the pipeline
// length is set by the one-bit-per-stage square root (2*W+3 stages)
// and the one-bit-per-stage divider (W stages).
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// A stall freezes the whole pipeline: in_ready is low only while the output
// register holds an item that has not been taken.
module ray_sphere_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [COORD_WIDTH-2:0] sphere_radius,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rsi_pkg::status_t              status,
    output logic signed [COORD_WIDTH-1:0] hit_distance,
    output logic                          saturated
);

    import rsi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = W + 1;          // p = origin - center
    localparam int AW   = 2 * W;          // A = d.d, unsigned
    localparam int HW   = 2 * W + 2;      // d.p
    localparam int BW   = 2 * W + 3;      // B = 2 d.p
    localparam int CW   = 2 * W + 3;      // C = p.p - r^2
    localparam int DW   = 4 * W + 6;      // discriminant
    localparam int SW   = DW / 2;         // square root
    localparam int RMW  = SW + 2;         // root remainder
    localparam int NMW  = 2 * W + 5;      // -B - s
    localparam int NW   = NMW - 1 + F;    // |num| scaled by 2^F
    localparam int DDW  = 2 * W + 1;      // divisor 2A
    localparam int RW0  = NW - W;         // dividend bits above the quotient window
    localparam int CMPW = (RW0 > DDW) ? RW0 : DDW;
    localparam int NST  = 11 + SW + W;    // pipeline stages

    localparam logic signed [W-1:0] MINUS_ONE = {W{1'b1}} << F;
    localparam logic [W-1:0]        T_MIN     = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]        T_MAX     = {1'b0, {(W-1){1'b1}}};

    logic en;
    logic [NST-1:0] valid_reg;

    // whole pipeline advances unless the output item is stuck
    assign en       = !valid_reg[NST-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    // ---- stage 1: p = origin - center ----
    logic signed [PW-1:0] p_reg [3];
    logic signed [W-1:0]  d_reg [3];
    logic signed [W-1:0]  rad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(origin_x) - PW'(center_x);
            p_reg[1] <= PW'(origin_y) - PW'(center_y);
            p_reg[2] <= PW'(origin_z) - PW'(center_z);
            d_reg[0] <= dir_x;
            d_reg[1] <= dir_y;
            d_reg[2] <= dir_z;
            rad_reg  <= $signed({1'b0, sphere_radius});
        end
    end

    // ---- stages 2-3: component products ----
    logic signed [2*W-1:0]   dd [3];
    logic signed [2*W:0]     dp [3];
    logic signed [2*W+1:0]   pp [3];
    logic signed [2*W-1:0]   rr;

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_dd (
            .clk (clk), .en (en), .a (d_reg[i]), .b (d_reg[i]), .p (dd[i])
        );
        rsi_mul #(.A_WIDTH(W), .B_WIDTH(PW)) u_dp (
            .clk (clk), .en (en), .a (d_reg[i]), .b (p_reg[i]), .p (dp[i])
        );
        rsi_mul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_pp (
            .clk (clk), .en (en), .a (p_reg[i]), .b (p_reg[i]), .p (pp[i])
        );
    end

    rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_rr (
        .clk (clk), .en (en), .a (rad_reg), .b (rad_reg), .p (rr)
    );

    // ---- stage 4: A, B, C ----
    logic signed [AW+1:0]  a_sum;
    logic signed [HW-1:0]  h_sum;
    logic        [AW-1:0]  a_reg;
    logic signed [BW-1:0]  b_reg;
    logic signed [CW-1:0]  c_reg;
    logic                  az_reg;

    assign a_sum = (AW+2)'(dd[0]) + (AW+2)'(dd[1]) + (AW+2)'(dd[2]);
    assign h_sum = HW'(dp[0]) + HW'(dp[1]) + HW'(dp[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a_sum[AW-1:0];
            b_reg  <= {h_sum, 1'b0};
            c_reg  <= CW'(pp[0]) + CW'(pp[1]) + CW'(pp[2]) - CW'(rr);
            az_reg <= (a_sum[AW-1:0] == '0);
        end
    end

    // ---- stages 5-6: B*B and A*C ----
    logic signed [2*BW-1:0]    bb;
    logic signed [AW+CW:0]     ac;
    logic        [AW-1:0]      a_d1_reg, a_d2_reg;
    logic signed [BW-1:0]      b_d1_reg, b_d2_reg;
    logic                      az_d1_reg, az_d2_reg;

    rsi_mul #(.A_WIDTH(BW), .B_WIDTH(BW)) u_bb (
        .clk (clk), .en (en), .a (b_reg), .b (b_reg), .p (bb)
    );
    rsi_mul #(.A_WIDTH(AW+1), .B_WIDTH(CW)) u_ac (
        .clk (clk), .en (en), .a ($signed({1'b0, a_reg})), .b (c_reg), .p (ac)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d1_reg  <= a_reg;
            a_d2_reg  <= a_d1_reg;
            b_d1_reg  <= b_reg;
            b_d2_reg  <= b_d1_reg;
            az_d1_reg <= az_reg;
            az_d2_reg <= az_d1_reg;
        end
    end

    // ---- stage 7: discriminant, then SW square-root stages ----
    logic signed [DW-1:0]  disc;
    logic [DW-1:0]         sq_x_reg    [0:SW];
    logic [RMW-1:0]        sq_rem_reg  [0:SW];
    logic [SW-1:0]         sq_root_reg [0:SW];
    logic [AW-1:0]         sq_a_reg    [0:SW];
    logic signed [BW-1:0]  sq_b_reg    [0:SW];
    logic                  sq_az_reg   [0:SW];
    logic                  sq_dn_reg   [0:SW];

    assign disc = DW'(bb) - (DW'(ac) <<< 2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg[0]    <= disc;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_a_reg[0]    <= a_d2_reg;
            sq_b_reg[0]    <= b_d2_reg;
            sq_az_reg[0]   <= az_d2_reg;
            sq_dn_reg[0]   <= disc[DW-1];
        end
    end

    // digit-by-digit root, one result bit per stage
    for (genvar j = 0; j < SW; j++)
    begin : g_sqrt
        logic [RMW-1:0] rem_t;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb
        begin
            rem_t = {sq_rem_reg[j][RMW-3:0], sq_x_reg[j][DW-1:DW-2]};
            trial = {sq_root_reg[j], 2'b01};
            ge    = (rem_t >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[j+1]  <= ge ? (rem_t - trial) : rem_t;
                sq_root_reg[j+1] <= {sq_root_reg[j][SW-2:0], ge};
                sq_x_reg[j+1]    <= sq_x_reg[j] << 2;
                sq_a_reg[j+1]    <= sq_a_reg[j];
                sq_b_reg[j+1]    <= sq_b_reg[j];
                sq_az_reg[j+1]   <= sq_az_reg[j];
                sq_dn_reg[j+1]   <= sq_dn_reg[j];
            end
        end
    end

    // ---- numerator -B - s, magnitude and scaling, range check ----
    logic signed [NMW-1:0] nm_reg;
    logic [AW-1:0]         nm_a_reg;
    logic                  nm_az_reg, nm_dn_reg;
    logic [NMW-1:0]        mag;
    logic [NW-1:0]         ab_n_reg;
    logic [DDW-1:0]        ab_d_reg;
    logic                  ab_neg_reg, ab_az_reg, ab_dn_reg;
    logic [CMPW-1:0]       hi_part;
    logic                  ovf;

    assign mag     = nm_reg[NMW-1] ? (NMW'(0) - nm_reg) : nm_reg;
    assign hi_part = CMPW'(ab_n_reg[NW-1:W]);
    assign ovf     = (hi_part >= CMPW'(ab_d_reg));

    logic [DDW-1:0]  dv_r_reg   [0:W];
    logic [W-1:0]    dv_q_reg   [0:W];
    logic [W-1:0]    dv_n_reg   [0:W];
    logic [DDW-1:0]  dv_d_reg   [0:W];
    logic            dv_neg_reg [0:W];
    logic            dv_ovf_reg [0:W];
    logic            dv_az_reg  [0:W];
    logic            dv_dn_reg  [0:W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_reg    <= NMW'(0) - NMW'(sq_b_reg[SW]) - NMW'({1'b0, sq_root_reg[SW]});
            nm_a_reg  <= sq_a_reg[SW];
            nm_az_reg <= sq_az_reg[SW];
            nm_dn_reg <= sq_dn_reg[SW];

            ab_n_reg   <= {mag[NMW-2:0], {F{1'b0}}};
            ab_d_reg   <= {nm_a_reg, 1'b0};
            ab_neg_reg <= nm_reg[NMW-1];
            ab_az_reg  <= nm_az_reg;
            ab_dn_reg  <= nm_dn_reg;

            // quotient >= 2^W means clamp; partial remainder cleared then
            dv_r_reg[0]   <= ovf ? '0 : hi_part[DDW-1:0];
            dv_q_reg[0]   <= '0;
            dv_n_reg[0]   <= ab_n_reg[W-1:0];
            dv_d_reg[0]   <= ab_d_reg;
            dv_neg_reg[0] <= ab_neg_reg;
            dv_ovf_reg[0] <= ovf;
            dv_az_reg[0]  <= ab_az_reg;
            dv_dn_reg[0]  <= ab_dn_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [DDW:0] rt;
        logic [DDW:0] diff;
        logic         ge;

        always_comb
        begin
            rt   = {dv_r_reg[k], dv_n_reg[k][W-1]};
            diff = rt - {1'b0, dv_d_reg[k]};
            ge   = (rt >= {1'b0, dv_d_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_r_reg[k+1]   <= ge ? diff[DDW-1:0] : rt[DDW-1:0];
                dv_q_reg[k+1]   <= {dv_q_reg[k][W-2:0], ge};
                dv_n_reg[k+1]   <= dv_n_reg[k] << 1;
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_ovf_reg[k+1] <= dv_ovf_reg[k];
                dv_az_reg[k+1]  <= dv_az_reg[k];
                dv_dn_reg[k+1]  <= dv_dn_reg[k];
            end
        end
    end

    // ---- output stage: sign, floor, clamp, special cases ----
    logic [W-1:0]  q;
    logic          rnz;
    status_t       st_next, st_reg;
    logic [W-1:0]  dist_next, dist_reg;
    logic          sat_next, sat_reg;

    assign q   = dv_q_reg[W];
    assign rnz = |dv_r_reg[W];

    always_comb
    begin
        st_next   = ST_HIT;
        dist_next = MINUS_ONE;
        sat_next  = 1'b0;
        priority if (dv_az_reg[W])
        begin
            st_next = ST_DEGEN;
        end
        else if (dv_dn_reg[W])
        begin
            st_next = ST_MISS;
        end
        else if (!dv_neg_reg[W])
        begin
            if (dv_ovf_reg[W] || q[W-1])
            begin
                dist_next = T_MAX;
                sat_next  = 1'b1;
            end
            else
            begin
                dist_next = q;
            end
        end
        else
        begin
            // negative root rounds toward minus infinity
            if (dv_ovf_reg[W] || (q > T_MIN) || ((q == T_MIN) && rnz))
            begin
                dist_next = T_MIN;
                sat_next  = 1'b1;
            end
            else
            begin
                dist_next = W'(0) - q - W'(rnz);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg   <= st_next;
            dist_reg <= dist_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid    = valid_reg[NST-1];
    assign status       = st_reg;
    assign hit_distance = dist_reg;
    assign saturated    = sat_reg;

`ifndef SYNTHESIS
    // miss and degenerate results always carry -1.0 and no clamp flag
    a_special_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_HIT) |-> (hit_distance == MINUS_ONE) && !saturated)
        else $error("special result without -1.0");

    // the clamp flag only accompanies a found root
    a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (status == ST_HIT))
        else $error("clamp flag on a non-hit result");

    // a stalled output freezes every valid bit in the pipeline
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the fixed-point ray/sphere intersection pipeline.
// A wide-integer predictor computes status, root and clamp flag for every
// item accepted on the input channel. A checker compares each output item,
// in order, against the oldest queued prediction.
module testbench;
    import rsi_pkg::*;

    localparam int CW        = 32;
    localparam int FB        = 16;
    localparam int DRAIN_CYC = 160;     // pipeline is 110 deep
    localparam int CYC_LIMIT = 600000;
    localparam int HOLD_CYC  = 400;     // long output stall

    typedef logic signed [319:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] cx, cy, cz;
        logic        [CW-2:0] rad;
        logic signed [CW-1:0] ox, oy, oz;
        logic signed [CW-1:0] dx, dy, dz;
    } ray_item_t;

    typedef struct {
        status_t              st;
        logic signed [CW-1:0] distance;
        logic                 sat;
    } hit_info_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] center_x = '0, center_y = '0, center_z = '0;
    logic        [CW-2:0] sphere_radius = '0;
    logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    status_t status;
    logic signed [CW-1:0] hit_distance;
    logic saturated;

    hit_info_t expected_hits[$];
    int  fail_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  sat_count = 0;
    int  cycle_count = 0;
    int  idle_pct = 0;      // sender idle chance per cycle
    int  stall_pct = 0;     // receiver stall chance per cycle
    bit  hold_req = 1'b0;   // asks the receiver for one long stall
    int  hold_left = 0;

    ray_sphere_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .sphere_radius(sphere_radius),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .hit_distance(hit_distance), .saturated(saturated)
    );

    always #5 clk = ~clk;

    // Floor integer square root; disc stays below 2^140, so root < 2^71.
    function automatic wide_t isqrt(input wide_t v);
        wide_t root, cand;
        root = '0;
        for (int b = 80; b >= 0; b--)
        begin
            cand = root | (wide_t'(1) <<< b);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    // Nearer root of |o + t*d - c|^2 = r^2, exact until the final clamp.
    function automatic hit_info_t solve_ray(input ray_item_t it);
        hit_info_t res;
        wide_t px, py, pz, dx, dy, dz, r, qa, qb, qc, disc, num, den, q;
        wide_t hi_lim, lo_lim;
        dx = wide_t'(it.dx); dy = wide_t'(it.dy); dz = wide_t'(it.dz);
        px = wide_t'(it.ox) - wide_t'(it.cx);
        py = wide_t'(it.oy) - wide_t'(it.cy);
        pz = wide_t'(it.oz) - wide_t'(it.cz);
        r  = wide_t'($signed({1'b0, it.rad}));
        qa = dx * dx + dy * dy + dz * dz;
        qb = (dx * px + dy * py + dz * pz) <<< 1;
        qc = px * px + py * py + pz * pz - r * r;
        disc = qb * qb - ((qa * qc) <<< 2);
        hi_lim = (wide_t'(1) <<< (CW - 1)) - 1;
        lo_lim = -(wide_t'(1) <<< (CW - 1));
        res.sat = 1'b0;
        res.distance = -(1 <<< FB);
        if (qa == 0)
            res.st = ST_DEGEN;
        else if (disc < 0)
            res.st = ST_MISS;
        else
        begin
            res.st = ST_HIT;
            num = (-qb - isqrt(disc)) <<< FB;
            den = qa <<< 1;
            q = num / den;
            if (num < 0 && (num % den) != 0)
                q = q - 1;
            if (q > hi_lim)
            begin
                q = hi_lim;
                res.sat = 1'b1;
            end
            else if (q < lo_lim)
            begin
                q = lo_lim;
                res.sat = 1'b1;
            end
            res.distance = q[CW-1:0];
        end
        return res;
    endfunction

    // Input monitor: predict on every accepted item.
    always @(posedge clk)
    begin
        ray_item_t it;
        if (rst_n && in_valid && in_ready)
        begin
            it.cx = center_x; it.cy = center_y; it.cz = center_z;
            it.rad = sphere_radius;
            it.ox = origin_x; it.oy = origin_y; it.oz = origin_z;
            it.dx = dir_x; it.dy = dir_y; it.dz = dir_z;
            expected_hits.push_back(solve_ray(it));
            sent_count++;
        end
    end

    // Output checker: in-order compare against the oldest prediction.
    always @(posedge clk)
    begin
        hit_info_t e;
        if (rst_n && out_valid && out_ready)
        begin
            checked_count++;
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected item status=%0d distance=%h", $time,
                         status, hit_distance);
                fail_count++;
            end
            else
            begin
                e = expected_hits.pop_front();
                if (e.sat)
                    sat_count++;
                if (status !== e.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, status);
                    fail_count++;
                end
                if (hit_distance !== e.distance)
                begin
                    $display("%0t: hit_distance exp %h got %h", $time, e.distance,
                             hit_distance);
                    fail_count++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated exp %0b got %0b", $time, e.sat,
                             saturated);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left <= HOLD_CYC;
            hold_req <= 1'b0;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one item; returns on the edge that accepted it.
    task automatic send_ray(input ray_item_t it);
        bit fire;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        center_x <= it.cx; center_y <= it.cy; center_z <= it.cz;
        sphere_radius <= it.rad;
        origin_x <= it.ox; origin_y <= it.oy; origin_z <= it.oz;
        dir_x <= it.dx; dir_y <= it.dy; dir_z <= it.dz;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            fire = in_valid && in_ready;
            @(posedge clk);
        end while (!fire);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] q16(input int v);
        return v <<< FB;
    endfunction

    function automatic ray_item_t mk(input int cx, cy, cz, rr, ox, oy, oz,
                                     dx, dy, dz);
        ray_item_t it;
        it.cx = q16(cx); it.cy = q16(cy); it.cz = q16(cz);
        it.rad = (CW-1)'(q16(rr));
        it.ox = q16(ox); it.oy = q16(oy); it.oz = q16(oz);
        it.dx = q16(dx); it.dy = q16(dy); it.dz = q16(dz);
        return it;
    endfunction

    // Full-range noise on every field.
    function automatic ray_item_t raw_ray();
        ray_item_t it;
        it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
        it.rad = (CW-1)'($urandom);
        it.ox = $urandom; it.oy = $urandom; it.oz = $urandom;
        it.dx = $urandom; it.dy = $urandom; it.dz = $urandom;
        return it;
    endfunction

    // Aimed ray: sphere placed near the ray line, so most items hit.
    function automatic ray_item_t aimed_ray();
        ray_item_t it;
        int k;
        it.ox = $signed($urandom) >>> $urandom_range(24, 8);
        it.oy = $signed($urandom) >>> $urandom_range(24, 8);
        it.oz = $signed($urandom) >>> $urandom_range(24, 8);
        it.dx = $signed($urandom) >>> $urandom_range(28, 12);
        it.dy = $signed($urandom) >>> $urandom_range(28, 12);
        it.dz = $signed($urandom) >>> $urandom_range(28, 12);
        k = $urandom_range(64) - 16;
        it.cx = it.ox + it.dx * k + ($signed($urandom) >>> 14);
        it.cy = it.oy + it.dy * k + ($signed($urandom) >>> 14);
        it.cz = it.oz + it.dz * k + ($signed($urandom) >>> 14);
        it.rad = (CW-1)'($urandom >> $urandom_range(14, 1));
        return it;
    endfunction

    task automatic test_directed();
        ray_item_t it;
        send_ray(mk(0, 0, 0, 1, 0, 0, -5, 0, 0, 1));       // plain hit, t = 4
        send_ray(mk(0, 0, 0, 1, 0, 0, 5, 0, 0, 1));        // sphere behind
        send_ray(mk(0, 0, 0, 3, 0, 0, 0, 1, 0, 0));        // origin inside
        send_ray(mk(0, 0, 0, 1, 0, 5, -5, 0, 0, 1));       // miss
        send_ray(mk(0, 0, 0, 1, 0, 1, -5, 0, 0, 1));       // tangent
        send_ray(mk(0, 0, 0, 1, 0, 0, -5, 0, 0, 0));       // zero direction
        send_ray(mk(0, 0, 0, 0, 0, 0, -5, 0, 0, 2));       // zero radius
        // Tiny direction far away: root clamps high.
        it = mk(0, 0, 30000, 1, 0, 0, -30000, 0, 0, 0);
        it.dz = 1;
        send_ray(it);
        // Tiny direction pointing away: root clamps low.
        it.dz = -1;
        send_ray(it);
        // Field extremes.
        it.cx = {1'b1, {(CW-1){1'b0}}}; it.cy = it.cx; it.cz = it.cx;
        it.ox = {1'b0, {(CW-1){1'b1}}}; it.oy = it.ox; it.oz = it.ox;
        it.dx = it.cx; it.dy = it.cx; it.dz = it.cx;
        it.rad = '1;
        send_ray(it);
        it.dx = it.ox; it.dy = it.ox; it.dz = it.ox;
        send_ray(it);
        it.rad = '0;
        send_ray(it);
        it.cx = it.ox; it.cy = it.ox; it.cz = it.ox;
        it.dx = '1; it.dy = '0; it.dz = '0;
        it.rad = '1;
        send_ray(it);
        it.dx = 1; it.dy = 1; it.dz = 1;
        send_ray(it);
        it = raw_ray();
        it.dx = '0; it.dy = '0; it.dz = '0;
        send_ray(it);
        settle();
    endtask

    task automatic test_random(input int n, input int ipct, input int spct);
        idle_pct = ipct;
        stall_pct = spct;
        repeat (n)
        begin
            if ($urandom_range(99) < 80)
                send_ray(aimed_ray());
            else
                send_ray(raw_ray());
        end
        settle();
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // Output held off while the sender keeps offering: pipeline fills.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (200)
            send_ray(aimed_ray());
        settle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 0, 0);
        test_random(350, 69, 0);
        test_random(350, 0, 69);
        test_random(250, 6, 6);
        test_backpressure();
        $display("%0d items sent, %0d results checked, %0d clamped roots",
                 sent_count, checked_count, sat_count);
        $display("covered hits, misses, zero directions, extremes and stalls");
        if (fail_count == 0 && expected_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/rsi_pkg.sv
rtl/rsi_mul.sv
rtl/ray_sphere_intersect.sv
tb/sv/testbench.sv
